@@ rtl/core/rcfrq_pkg.sv @@
// ----------------------------------------------------------------------------
// rcfrq_pkg
// Types and constants shared by the rolling-code frame receive queue.
// ----------------------------------------------------------------------------
`default_nettype none

package rcfrq_pkg;

    // Field widths
    localparam int unsigned FRAME_W   = 56;
    localparam int unsigned TIME_W    = 48;
    localparam int unsigned REMOTE_W  = 24;
    localparam int unsigned ROLL_W    = 16;
    localparam int unsigned BUTTON_W  = 4;
    localparam int unsigned REPEAT_W  = 16;
    localparam int unsigned HOLDOFF_W = 24;
    localparam int unsigned BTNMASK_W = 16;
    localparam int unsigned CFG_W     = 24;

    // Decode masks
    localparam logic [7:0] BUTTON_MASK = 8'hf0;
    localparam logic [7:0] CHECK_MASK  = 8'h0f;

    // Configuration reset values
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 24'd250000;
    localparam logic [BTNMASK_W-1:0] BUTTONS_RESET = 16'd22;

    // Command codes
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_HOLDOFF = 1'b0;
    localparam logic CFG_BUTTONS = 1'b1;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_MERGED   = 3'd1,
        ST_REJECTED = 3'd2,
        ST_DROPPED  = 3'd3,
        ST_READ_OK  = 3'd4,
        ST_EMPTY    = 3'd5,
        ST_HELD_OFF = 3'd6
    } status_t;

    // Decoded frame
    typedef struct packed {
        logic                ok;
        logic [REMOTE_W-1:0] remote_id;
        logic [ROLL_W-1:0]   rolling_code;
        logic [BUTTON_W-1:0] button;
    } dec_t;

    // One ring entry
    typedef struct packed {
        logic [REMOTE_W-1:0] remote_id;
        logic [ROLL_W-1:0]   rolling_code;
        logic [BUTTON_W-1:0] button;
        logic [REPEAT_W-1:0] repeat_count;
        logic [TIME_W-1:0]   last_time;
    } entry_t;

    // One result
    typedef struct packed {
        status_t             status;
        logic [REMOTE_W-1:0] remote_id;
        logic [ROLL_W-1:0]   rolling_code;
        logic [BUTTON_W-1:0] button;
        logic [REPEAT_W-1:0] repeat_count;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/core/rcfrq_item_if.sv @@
// ----------------------------------------------------------------------------
// rcfrq_item_if
// Input channel: a received frame or a read request with its timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcfrq_item_if
    import rcfrq_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [FRAME_W-1:0] frame;
    logic [TIME_W-1:0]  now_us;

    modport source (output valid, output cmd, output frame, output now_us, input ready);
    modport sink   (input valid, input cmd, input frame, input now_us, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rcfrq_result_if.sv @@
// ----------------------------------------------------------------------------
// rcfrq_result_if
// Output channel: one status and entry fields per input transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcfrq_result_if
    import rcfrq_pkg::*;
;
    logic                valid;
    logic                ready;
    status_t             status;
    logic [REMOTE_W-1:0] remote_id;
    logic [ROLL_W-1:0]   rolling_code;
    logic [BUTTON_W-1:0] button;
    logic [REPEAT_W-1:0] repeat_count;

    modport source (output valid, output status, output remote_id, output rolling_code,
                    output button, output repeat_count, input ready);
    modport sink   (input valid, input status, input remote_id, input rolling_code,
                    input button, input repeat_count, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rolling_code_frame_receive_queue.sv @@
// ----------------------------------------------------------------------------
// rolling_code_frame_receive_queue
// Receive queue for rolling-code remote frames: decode, checksum and button
// check, repeat merge into the newest entry, and delayed read of the oldest.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+--------------------------------------------
//  item     | in  | valid / ready   | cmd, frame[55:0], now_us[47:0]
//  result   | out | valid / ready   | status, remote_id, rolling_code, button,
//           |     |                 | repeat_count
//  cfg      | in  | cfg_we          | cfg_index, cfg_wdata[23:0]
//
//  One transaction per cycle sustained while results are taken; each passes
//  from input to result through an input register, then decode and ring
//  update into the result register. The ring memory's registered read port
//  prefetches the oldest entry so a read finishes in the same single pass.
//  Reset clears the slots, fill count, valid flags and restores the
//  configuration; no clearing pass. A stalled result holds in its register
//  while one more item waits in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module rolling_code_frame_receive_queue
    import rcfrq_pkg::*;
#(
    parameter int unsigned RING_DEPTH = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    rcfrq_item_if.sink            item,
    rcfrq_result_if.source        result,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    logic                 in_valid_reg;
    logic                 in_cmd_reg;
    logic [FRAME_W-1:0]   in_frame_reg;
    logic [TIME_W-1:0]    in_now_reg;
    logic                 res_valid_reg;
    res_t                 res_reg;
    logic [HOLDOFF_W-1:0] holdoff_reg;
    logic [BTNMASK_W-1:0] buttons_reg;

    logic advance;
    dec_t dec;
    res_t res;

    // Advance when the result register is free or being emptied
    assign advance    = in_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_reg <= HOLDOFF_RESET;
            buttons_reg <= BUTTONS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HOLDOFF: holdoff_reg <= cfg_wdata[HOLDOFF_W-1:0];
                CFG_BUTTONS: buttons_reg <= cfg_wdata[BTNMASK_W-1:0];
                default:     holdoff_reg <= holdoff_reg;
            endcase
        end
    end

    // Input register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_cmd_reg   <= item.cmd;
            in_frame_reg <= item.frame;
            in_now_reg   <= item.now_us;
        end
    end

    rcfrq_decode u_decode (
        .frame            (in_frame_reg),
        .accepted_buttons (buttons_reg),
        .dec              (dec)
    );

    rcfrq_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (advance),
        .cmd        (in_cmd_reg),
        .dec        (dec),
        .now_us     (in_now_reg),
        .holdoff_us (holdoff_reg),
        .res        (res)
    );

    // Result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.status       = res_reg.status;
    assign result.remote_id    = res_reg.remote_id;
    assign result.rolling_code = res_reg.rolling_code;
    assign result.button       = res_reg.button;
    assign result.repeat_count = res_reg.repeat_count;

endmodule

`default_nettype wire

@@ rtl/core/rcfrq_decode.sv @@
// ----------------------------------------------------------------------------
// rcfrq_decode
// Undo the chained XOR of a raw frame, check the nibble checksum and the
// button against the accepted mask.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfrq_decode
    import rcfrq_pkg::*;
(
    input  wire logic [FRAME_W-1:0]   frame,
    input  wire logic [BTNMASK_W-1:0] accepted_buttons,
    output dec_t                      dec
);

    logic [7:0] raw [7];
    logic [7:0] plain [7];
    logic [3:0] given;
    logic [3:0] sum;

    // Split bytes, byte 0 on top, and undo the XOR chain
    always_comb
    begin
        for (int i = 0; i < 7; i++)
        begin
            raw[i] = frame[FRAME_W-1-8*i -: 8];
        end
        plain[0] = raw[0];
        for (int i = 1; i < 7; i++)
        begin
            plain[i] = raw[i] ^ raw[i-1];
        end
    end

    // Checksum over all nibbles, with the checksum nibble taken as zero
    always_comb
    begin
        given = plain[1][3:0] & CHECK_MASK[3:0];
        sum   = plain[0][7:4] ^ plain[0][3:0] ^ (plain[1][7:4] & BUTTON_MASK[7:4]);
        for (int i = 2; i < 7; i++)
        begin
            sum = sum ^ plain[i][7:4] ^ plain[i][3:0];
        end
    end

    // Unpack fields and qualify
    always_comb
    begin
        dec.button       = plain[1][7:4];
        dec.rolling_code = {plain[2], plain[3]};
        dec.remote_id    = {plain[4], plain[5], plain[6]};
        dec.ok           = (sum == given) && accepted_buttons[plain[1][7:4]];
    end

endmodule

`default_nettype wire

@@ rtl/core/rcfrq_ring.sv @@
// ----------------------------------------------------------------------------
// rcfrq_ring
// Entry ring with newest-entry shadow registers, repeat merge, hold-off
// check on read, and the result of one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfrq_ring
    import rcfrq_pkg::*;
#(
    parameter int unsigned RING_DEPTH = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 go,
    input  wire logic                 cmd,
    input  wire dec_t                 dec,
    input  wire logic [TIME_W-1:0]    now_us,
    input  wire logic [HOLDOFF_W-1:0] holdoff_us,
    output res_t                      res
);

    localparam int unsigned SLOT_W = $clog2(RING_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
    localparam logic [SLOT_W-1:0] ONE       = SLOT_W'(1);

    // Entry memory, one write and one registered read port
    entry_t mem [RING_DEPTH];
    entry_t rd_data_reg;

    // Ring control
    logic [SLOT_W-1:0] wr_slot_reg, wr_slot_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic [SLOT_W-1:0] held_reg, held_next;

    // Shadow of the newest entry
    logic [REMOTE_W-1:0] nw_remote_reg, nw_remote_next;
    logic [ROLL_W-1:0]   nw_roll_reg, nw_roll_next;
    logic [BUTTON_W-1:0] nw_button_reg, nw_button_next;
    logic [REPEAT_W-1:0] nw_rep_reg, nw_rep_next;

    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    entry_t            mem_wdata;

    logic              held_nz;
    logic              match;
    logic              full;
    logic [SLOT_W-1:0] wr_inc;
    logic [SLOT_W-1:0] rd_inc;
    logic [TIME_W:0]   age;
    logic              held_off;

    assign held_nz = (held_reg != '0);
    assign match   = held_nz && (nw_remote_reg == dec.remote_id)
                     && (nw_roll_reg == dec.rolling_code) && (nw_button_reg == dec.button);
    assign full    = (held_reg == LAST_SLOT);
    assign wr_inc  = (wr_slot_reg == LAST_SLOT) ? '0 : wr_slot_reg + ONE;
    assign rd_inc  = (rd_slot_reg == LAST_SLOT) ? '0 : rd_slot_reg + ONE;

    // Age of the oldest entry; the borrow bit marks time going backwards
    assign age      = {1'b0, now_us} - {1'b0, rd_data_reg.last_time};
    assign held_off = age[TIME_W] ||
                      (age[TIME_W-1:0] < {{(TIME_W-HOLDOFF_W){1'b0}}, holdoff_us});

    // Decide the transaction's effect and result
    always_comb
    begin
        wr_slot_next   = wr_slot_reg;
        rd_slot_next   = rd_slot_reg;
        held_next      = held_reg;
        nw_remote_next = nw_remote_reg;
        nw_roll_next   = nw_roll_reg;
        nw_button_next = nw_button_reg;
        nw_rep_next    = nw_rep_reg;
        mem_we         = 1'b0;
        mem_waddr      = wr_slot_reg;
        mem_wdata      = '{remote_id: dec.remote_id, rolling_code: dec.rolling_code,
                           button: dec.button, repeat_count: '0, last_time: now_us};

        res = '{status: ST_REJECTED, remote_id: dec.remote_id,
                rolling_code: dec.rolling_code, button: dec.button, repeat_count: '0};

        if (cmd == CMD_FRAME)
        begin
            if (!dec.ok)
            begin
                res.status = ST_REJECTED;
            end
            else if (match)
            begin
                // Merge a repeat into the newest entry
                res.status             = ST_MERGED;
                nw_rep_next            = nw_rep_reg + REPEAT_W'(1);
                mem_we                 = go;
                mem_wdata.repeat_count = nw_rep_next;
            end
            else if (full)
            begin
                res.status = ST_DROPPED;
            end
            else
            begin
                // Store a new entry
                res.status     = ST_STORED;
                mem_we         = go;
                mem_waddr      = held_nz ? wr_inc : wr_slot_reg;
                wr_slot_next   = mem_waddr;
                held_next      = held_reg + ONE;
                nw_remote_next = dec.remote_id;
                nw_roll_next   = dec.rolling_code;
                nw_button_next = dec.button;
                nw_rep_next    = '0;
            end
        end
        else
        begin
            res.remote_id    = '0;
            res.rolling_code = '0;
            res.button       = '0;
            if (!held_nz)
            begin
                res.status = ST_EMPTY;
            end
            else if (held_off)
            begin
                res.status = ST_HELD_OFF;
            end
            else
            begin
                // Hand out the oldest entry
                res.status       = ST_READ_OK;
                res.remote_id    = rd_data_reg.remote_id;
                res.rolling_code = rd_data_reg.rolling_code;
                res.button       = rd_data_reg.button;
                res.repeat_count = rd_data_reg.repeat_count;
                held_next        = held_reg - ONE;
                rd_slot_next     = rd_inc;
                if (held_reg == ONE)
                begin
                    wr_slot_next = rd_inc;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_slot_reg <= '0;
            rd_slot_reg <= '0;
            held_reg    <= '0;
        end
        else if (go)
        begin
            wr_slot_reg <= wr_slot_next;
            rd_slot_reg <= rd_slot_next;
            held_reg    <= held_next;
        end
    end

    // Newest-entry shadow, valid only while the ring holds entries
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            nw_remote_reg <= nw_remote_next;
            nw_roll_reg   <= nw_roll_next;
            nw_button_reg <= nw_button_next;
            nw_rep_reg    <= nw_rep_next;
        end
    end

    // Write the entry memory; prefetch the oldest entry with write bypass
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_we && (mem_waddr == (go ? rd_slot_next : rd_slot_reg)))
        begin
            rd_data_reg <= mem_wdata;
        end
        else
        begin
            rd_data_reg <= mem[go ? rd_slot_next : rd_slot_reg];
        end
    end

endmodule

`default_nettype wire
